// ===== design/cfb_pkg.sv =====
// cfb_pkg: shared types and constants of the checksummed frame builder
// no dependencies; imported by every design file of the block
package cfb_pkg;

    localparam logic [15:0] PORT_TYPE0 = 16'h1874;
    localparam logic [15:0] PORT_TYPE4 = 16'h0ECE;
    localparam logic [3:0]  TYPE_SEL0  = 4'd0;
    localparam logic [3:0]  TYPE_SEL4  = 4'd4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic CFG_VERSION  = 1'b0;
    localparam logic CFG_SRC_PORT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  msg_type;
        logic [11:0] body_len;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_out_item;

    // byte handed to the checksum accumulator
    typedef struct packed {
        logic       add;
        logic       restart;
        logic [7:0] data;
    } t_sum_ctl;

endpackage

// ===== design/checksummed_frame_builder.sv =====
// A start transaction opens a frame and produces a 7-byte header plus a zero pad
// byte when the length is even; each data transaction of an open frame passes
// its byte through, and the last one is followed by the two checksum bytes
// (high first, frame_end on the second); a zero-length start is closed the same
// way. Output is one byte per cycle, while the receiver does not stall, from a
// single output register. Data transactions with no open frame are taken and
// dropped. Configuration writes are plain register writes; the user must make
// them only while idle, as the block does not enforce it.
// depends on cfb_pkg, cfb_seq, cfb_csum
module checksummed_frame_builder
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]  r_version;
    logic [15:0] r_src_port;
    logic        r_ov;
    t_out_item   r_oitem;

    logic        out_free;
    logic        take;
    logic        emit;
    t_out_item   seq_item;
    t_sum_ctl    sum_ctl;
    logic [15:0] check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version  <= 8'h00;
            r_src_port <= 16'h0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VERSION:  r_version  <= i_cfg_data[7:0];
                CFG_SRC_PORT: r_src_port <= i_cfg_data;
                default:      r_version  <= r_version;
            endcase
        end
    end

    assign out_free = !r_ov || !i_stall;

    cfb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_take     (take),
        .i_item     (i_item),
        .i_version  (r_version),
        .i_src_port (r_src_port),
        .i_check    (check),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_item     (seq_item),
        .o_sum_ctl  (sum_ctl)
    );

    cfb_csum u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sum_ctl),
        .o_check (check)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_oitem <= seq_item;
        end
    end

    assign o_stall = !take;
    assign o_valid = r_ov;
    assign o_item  = r_oitem;

endmodule

// ===== design/cfb_csum.sv =====
// cfb_csum: ones' complement sum of big-endian byte pairs, end-around carry
// depends on cfb_pkg (t_sum_ctl)
module cfb_csum
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sum_ctl    i_ctl,
    output logic [15:0] o_check
);

    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_held, n_held;
    logic        r_odd, n_odd;
    logic [16:0] pair_sum;

    assign pair_sum = {1'b0, r_sum} + {1'b0, r_held, i_ctl.data};

    always_comb begin
        n_sum  = r_sum;
        n_held = r_held;
        n_odd  = r_odd;
        if (i_ctl.add) begin
            if (i_ctl.restart) begin
                n_sum  = 16'h0000;
                n_held = i_ctl.data;
                n_odd  = 1'b1;
            end else if (!r_odd) begin
                n_held = i_ctl.data;
                n_odd  = 1'b1;
            end else begin
                // end-around carry
                n_sum = pair_sum[15:0] + {15'd0, pair_sum[16]};
                n_odd = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 16'h0000;
            r_held <= 8'h00;
            r_odd  <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_held <= n_held;
            r_odd  <= n_odd;
        end
    end

    assign o_check = ~r_sum;

endmodule

// ===== design/cfb_seq.sv =====
// cfb_seq: holds the current item and frame state, steps out one byte per cycle while the output is free
// depends on cfb_pkg (item types, codes, port constants)
module cfb_seq
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_take,
    input  t_in_item    i_item,
    input  logic [7:0]  i_version,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_check,
    input  logic        i_out_free,
    output logic        o_emit,
    output t_out_item   o_item,
    output t_sum_ctl    o_sum_ctl
);

    localparam logic [1:0] PH_HDR   = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_CK_HI = 2'd2;
    localparam logic [1:0] PH_CK_LO = 2'd3;

    logic        r_busy, n_busy;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [3:0]  r_type;
    logic [11:0] r_len;
    logic [7:0]  r_data;
    logic        r_last, n_last;
    logic        r_open, n_open;
    logic [11:0] r_remain, n_remain;

    logic [15:0] dst_port;
    logic [2:0]  hdr_last_idx;
    logic        step_done;
    logic        accept;
    logic [7:0]  hdr_byte;

    always_comb begin
        if (r_type == TYPE_SEL0) begin
            dst_port = PORT_TYPE0;
        end else if (r_type == TYPE_SEL4) begin
            dst_port = PORT_TYPE4;
        end else begin
            dst_port = 16'h0000;
        end
    end

    // odd length: no pad byte
    assign hdr_last_idx = r_len[0] ? 3'd6 : 3'd7;

    always_comb begin
        case (r_idx)
            3'd0:    hdr_byte = i_version;
            3'd1:    hdr_byte = i_src_port[7:0];
            3'd2:    hdr_byte = i_src_port[15:8];
            3'd3:    hdr_byte = dst_port[7:0];
            3'd4:    hdr_byte = dst_port[15:8];
            3'd5:    hdr_byte = r_len[7:0];
            3'd6:    hdr_byte = {r_type, r_len[11:8]};
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        o_item.frame_end = 1'b0;
        step_done        = 1'b0;
        unique case (r_phase)
            PH_HDR: begin
                o_item.out_byte = hdr_byte;
                step_done = (r_idx == hdr_last_idx) && (r_len != 12'd0);
            end
            PH_DATA: begin
                o_item.out_byte = r_data;
                step_done = !r_last;
            end
            PH_CK_HI: begin
                o_item.out_byte = i_check[15:8];
            end
            PH_CK_LO: begin
                o_item.out_byte = i_check[7:0];
                o_item.frame_end = 1'b1;
                step_done = 1'b1;
            end
            default: begin
                o_item.out_byte = 8'h00;
            end
        endcase
    end

    assign o_emit = r_busy && i_out_free;
    assign o_take = !r_busy || (o_emit && step_done);
    assign accept = i_valid && o_take;

    assign o_sum_ctl.add     = o_emit && ((r_phase == PH_HDR) || (r_phase == PH_DATA));
    assign o_sum_ctl.restart = (r_phase == PH_HDR) && (r_idx == 3'd0);
    assign o_sum_ctl.data    = o_item.out_byte;

    always_comb begin
        n_busy   = r_busy;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_last   = r_last;
        n_open   = r_open;
        n_remain = r_remain;
        if (accept) begin
            n_idx = 3'd0;
            if (i_item.cmd == CMD_START) begin
                n_busy   = 1'b1;
                n_phase  = PH_HDR;
                n_last   = 1'b0;
                n_open   = (i_item.body_len != 12'd0);
                n_remain = i_item.body_len;
            end else if (r_open) begin
                n_busy   = 1'b1;
                n_phase  = PH_DATA;
                n_last   = (r_remain == 12'd1);
                n_open   = (r_remain != 12'd1);
                n_remain = r_remain - 12'd1;
            end else begin
                // no open frame: item dropped
                n_busy = 1'b0;
            end
        end else if (o_emit) begin
            if (step_done) begin
                n_busy = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_HDR: begin
                        if (r_idx == hdr_last_idx) begin
                            n_phase = PH_CK_HI;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    PH_DATA:  n_phase = PH_CK_HI;
                    PH_CK_HI: n_phase = PH_CK_LO;
                    default:  n_phase = PH_CK_LO;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_HDR;
            r_idx    <= 3'd0;
            r_last   <= 1'b0;
            r_open   <= 1'b0;
            r_remain <= 12'd0;
        end else begin
            r_busy   <= n_busy;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_last   <= n_last;
            r_open   <= n_open;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= i_item.msg_type;
            r_len  <= i_item.body_len;
            r_data <= i_item.data_byte;
        end
    end

endmodule

// ===== design/cfb_checker.sv =====
// cfb_checker: port-level assertions for checksummed_frame_builder, with its bind
// depends on cfb_pkg (item types)
module cfb_checker
    import cfb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_item,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled output transaction changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a header is several bytes long, so a start blocks the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_item.cmd == CMD_START) |=> o_stall)
        else $error("input taken during header");

    // no two frame end bytes in a row on the output
    a_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_item.frame_end |=> !(o_valid && o_item.frame_end))
        else $error("two frame end bytes in a row");

endmodule

bind checksummed_frame_builder cfb_checker u_cfb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_item  (i_item),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// ===== sim/checksummed_frame_builder_test.sv =====
`timescale 1ns / 100ps
// checksummed_frame_builder_test: self-checking bench for the checksummed frame builder
// holds its own byte-level predictor, a directed stimulus table and random framed traffic
// depends on cfb_pkg and checksummed_frame_builder
module checksummed_frame_builder_test;
    import cfb_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int DRAIN_CYCLES    = 12;
    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam int RANDOM_ITEMS    = 120;
    localparam int PHASES          = 4;
    localparam int MAX_PRINTS      = 200;

    typedef struct {
        t_in_item    item;
        bit          typed;
        logic [15:0] csum;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_item;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    // predictor state
    logic [7:0]  cfg_version;
    logic [15:0] cfg_src_port;
    logic [15:0] csum_acc;
    logic [7:0]  csum_hi;
    logic        csum_odd;
    logic [11:0] bytes_left;
    logic        frame_open;
    t_out_item   frame_bytes_q[$];

    int errors;
    int items_sent;
    int burst_left;
    bit hold_off_req;
    bit hold_off_done;

    checksummed_frame_builder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(logic cmd, logic [3:0] typ, logic [11:0] len,
                                           logic [7:0] b);
        t_in_item it;
        it.cmd       = cmd;
        it.msg_type  = typ;
        it.body_len  = len;
        it.data_byte = b;
        return it;
    endfunction

    function automatic t_stim_row stim_row(t_in_item it, bit typed, logic [15:0] csum);
        t_stim_row r;
        r.item  = it;
        r.typed = typed;
        r.csum  = csum;
        return r;
    endfunction

    // ones' complement add of big-endian byte pairs, end-around carry
    function void fold_byte(logic [7:0] b);
        logic [16:0] s;
        if (!csum_odd) begin
            csum_hi  = b;
            csum_odd = 1'b1;
        end else begin
            s        = {1'b0, csum_acc} + {1'b0, csum_hi, b};
            csum_acc = s[15:0] + 16'(s[16]);
            csum_odd = 1'b0;
        end
    endfunction

    function void push_byte(logic [7:0] b, logic last, bit add);
        t_out_item r;
        r.out_byte  = b;
        r.frame_end = last;
        frame_bytes_q.push_back(r);
        if (add) fold_byte(b);
    endfunction

    function void close_frame();
        logic [15:0] c;
        c = ~csum_acc;
        push_byte(c[15:8], 1'b0, 1'b0);
        push_byte(c[7:0], 1'b1, 1'b0);
        frame_open = 1'b0;
        bytes_left = '0;
    endfunction

    function void predict_frame_bytes(t_in_item it);
        logic [15:0] dst;
        if (it.cmd == CMD_START) begin
            case (it.msg_type)
                TYPE_SEL0: dst = PORT_TYPE0;
                TYPE_SEL4: dst = PORT_TYPE4;
                default:   dst = '0;
            endcase
            csum_acc = '0;
            csum_hi  = '0;
            csum_odd = 1'b0;
            push_byte(cfg_version, 1'b0, 1'b1);
            push_byte(cfg_src_port[7:0], 1'b0, 1'b1);
            push_byte(cfg_src_port[15:8], 1'b0, 1'b1);
            push_byte(dst[7:0], 1'b0, 1'b1);
            push_byte(dst[15:8], 1'b0, 1'b1);
            push_byte(it.body_len[7:0], 1'b0, 1'b1);
            push_byte({it.msg_type, it.body_len[11:8]}, 1'b0, 1'b1);
            // even length gets a zero pad byte
            if (!it.body_len[0]) push_byte(8'h00, 1'b0, 1'b1);
            if (it.body_len == '0) begin
                close_frame();
            end else begin
                bytes_left = it.body_len;
                frame_open = 1'b1;
            end
        end else if (frame_open) begin
            push_byte(it.data_byte, 1'b0, 1'b1);
            bytes_left = bytes_left - 12'd1;
            if (bytes_left == '0) close_frame();
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < MAX_PRINTS)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // output side: compare every accepted transaction with the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_out_item want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (frame_bytes_q.size() == 0) begin
                report_mismatch("byte with nothing pending", int'(o_item.out_byte), -1);
            end else begin
                want = frame_bytes_q.pop_front();
                if (o_item.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(o_item.out_byte),
                                    int'(want.out_byte));
                if (o_item.frame_end !== want.frame_end)
                    report_mismatch("frame_end", int'(o_item.frame_end),
                                    int'(want.frame_end));
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : receiver
        int seg_left;
        int density;
        int hold_left;
        seg_left  = 0;
        density   = 0;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                hold_left     = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 60);
                    case ($urandom_range(0, 3))
                        0:       density = 0;
                        1:       density = 20;
                        2:       density = 50;
                        default: density = 85;
                    endcase
                end
                seg_left--;
                i_stall <= ($urandom_range(0, 99) < density);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // called just after a falling edge; returns just after a falling edge, once the item has been taken
    task automatic send_item(t_in_item it);
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
        predict_frame_bytes(it);
    endtask

    task automatic offer(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        // stray data transactions are dropped and do not count
        if (it.cmd == CMD_START || frame_open) items_sent++;
        send_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (frame_bytes_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [7:0] ver, logic [15:0] port);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_VERSION;
        i_cfg_data <= {8'h00, ver};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SRC_PORT;
        i_cfg_data <= port;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_version  = ver;
        cfg_src_port = port;
    endtask

    task automatic random_frame();
        int pick;
        int len;
        int k;
        logic [3:0] typ;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            offer(make_item(CMD_DATA, 4'($urandom), 12'($urandom), 8'($urandom)));
        end else begin
            case ($urandom_range(0, 3))
                0:       typ = TYPE_SEL0;
                1:       typ = TYPE_SEL4;
                default: typ = 4'($urandom);
            endcase
            if (pick < 14)      len = 0;
            else if (pick < 24) len = $urandom_range(1, 4095);
            else if (pick < 34) len = $urandom_range(13, 40);
            else                len = $urandom_range(1, 12);
            offer(make_item(CMD_START, typ, 12'(len), 8'($urandom)));
            // broken frames stop early and get abandoned by the next start
            k = (pick < 24) ? $urandom_range(0, 5) : len;
            repeat (k)
                offer(make_item(CMD_DATA, 4'($urandom), 12'($urandom), 8'($urandom)));
        end
    endtask

    initial begin : stimulus
        t_stim_row dir_rows[$];
        logic [7:0]  ver;
        logic [15:0] port;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_VERSION;
        i_cfg_data = '0;
        errors        = 0;
        items_sent    = 0;
        burst_left    = 0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        cfg_version   = '0;
        cfg_src_port  = '0;
        csum_acc      = '0;
        csum_hi       = '0;
        csum_odd      = 1'b0;
        bytes_left    = '0;
        frame_open    = 1'b0;

        // directed rows, run with the register values after reset
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'h5A), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd0, 12'd0, 8'h00), 1'b1, 16'hE78B));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd4, 12'd0, 8'h00), 1'b1, 16'hB131));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd15, 12'd0, 8'h00), 1'b1, 16'h0FFF));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd0, 12'd1, 8'h00), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'hFF), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd4, 12'd2, 8'h00), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'h00), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd15, 12'hFFF, 8'hFF), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd3, 12'hFFF, 8'h00), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'h80), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'h01), 1'b0, '0));
        // a start in the middle of a frame abandons it
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd9, 12'd3, 8'h00), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'hA5), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd15, 12'd1, 8'hFF), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'h7E), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'h33), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd2, 12'h800, 8'h00), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_START, 4'd0, 12'd2, 8'h00), 1'b0, '0));
        // all-ones payload forces the end-around carry
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'hFF), 1'b0, '0));
        dir_rows.push_back(stim_row(make_item(CMD_DATA, 4'd0, 12'd0, 8'hFF), 1'b0, '0));

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            offer(dir_rows[r].item);
            if (dir_rows[r].typed) begin
                frame_bytes_q[$-1].out_byte = dir_rows[r].csum[15:8];
                frame_bytes_q[$].out_byte   = dir_rows[r].csum[7:0];
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin ver = 8'hFF;         port = 16'hFFFF;         end
                2:       begin ver = 8'h00;         port = 16'h0000;         end
                default: begin ver = 8'($urandom);  port = 16'($urandom);    end
            endcase
            configure(ver, port);
            items_sent = 0;
            if (p == 1) hold_off_req = 1'b1;
            while (items_sent < RANDOM_ITEMS / PHASES) random_frame();
        end

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
